// File: rtl/mpe_pkg.sv
// ----------------------------------------------------------------------------
// mpe_pkg
// Shared constants and types for the Mandelbrot pixel engine.
// ----------------------------------------------------------------------------
package mpe_pkg;

	localparam int MAX_SIDE_DEF  = 4096;
	localparam int FRAC_BITS_DEF = 28;

	localparam int IDX_W  = 24;
	localparam int OFS_W  = 24;
	localparam int SIDE_W = 13;
	localparam int ITER_W = 10;
	localparam int SCL_W  = 31;
	localparam int FIX_W  = 32;
	localparam int ADDR_W = 22;
	localparam int BYTE_W = 8;
	localparam int QTR_W  = 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ITERS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CRE    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CIM    = 3'd6;

	localparam logic [SIDE_W-1:0] WIDTH_RST  = 13'd4096;
	localparam logic [SIDE_W-1:0] HEIGHT_RST = 13'd4096;
	localparam logic [ITER_W-1:0] ITERS_RST  = 10'd150;
	localparam logic [SCL_W-1:0]  SCALE_RST  = 31'd268435;
	localparam logic signed [FIX_W-1:0] CRE_RST = -32'sd376614945;
	localparam logic signed [FIX_W-1:0] CIM_RST = 32'sd0;

	// divider handshake
	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;

endpackage

// File: rtl/mandelbrot_pixel_engine.sv
// ----------------------------------------------------------------------------
// mandelbrot_pixel_engine
// Escape-time Mandelbrot pixel engine in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: pulse start with pixel_index while busy is low. The word
//   is taken at that edge and busy rises until the result is out.
//   Result channel: strobe is high for one cycle with quarter,
//   quarter_address, real_byte and imag_byte. The receiver cannot stall; the
//   result must be captured in that cycle. An index whose sum with the offset
//   is at or past width*height gives no strobe, and busy never rises for it.
//   Config channel: cfg_valid/cfg_ready with cfg_index/cfg_data; ready is
//   always high. Write only while busy is low.
// Sequence: a launch state (S_START), then three divisions on one shared
//   serial divider (index/width, col<<FRAC_BITS / width and
//   row<<FRAC_BITS / height), S_CX, S_CY and S_LDY to build c, rounds of
//   S_MXX, S_MYY, S_MXY and S_UPD on the single shared 33x33 multiplier
//   (x*x, y*y, x*y, then escape test and update), one extra round slot for
//   the final escape test, and S_BX, S_BY and S_OUT for the two bytes.
//   strobe follows in the first idle cycle, where the next word may already
//   be taken, so a new word is taken only once the last result is out. An
//   escaped point stops at the round where it escapes.
// Reset: registers take their default view (4096x4096, 150 rounds, scale
//   0.001, centre -1.403), the sequencer returns to idle.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_engine #(
	parameter int MAX_SIDE  = mpe_pkg::MAX_SIDE_DEF,
	parameter int FRAC_BITS = mpe_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [mpe_pkg::IDX_W-1:0]         pixel_index,
	output logic                              strobe,
	output logic [mpe_pkg::QTR_W-1:0]         quarter,
	output logic [mpe_pkg::ADDR_W-1:0]        quarter_address,
	output logic [mpe_pkg::BYTE_W-1:0]        real_byte,
	output logic [mpe_pkg::BYTE_W-1:0]        imag_byte,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mpe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mpe_pkg::CFG_DATA_W-1:0]    cfg_data
);
	localparam int SW    = mpe_pkg::SIDE_W;
	localparam int FW    = mpe_pkg::FIX_W;
	localparam int IW    = mpe_pkg::IDX_W + 1;     // index plus offset
	localparam int NUM_W = (IW > SW + FRAC_BITS) ? IW : SW + FRAC_BITS;
	localparam int PW    = 2 * FW;
	localparam int TW    = 2 * SW;                 // total pixel count width
	localparam int CW    = (IW > TW) ? IW : TW;    // index vs total compares

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DIVI  = 4'd1;
	localparam logic [3:0] S_DIVX  = 4'd2;
	localparam logic [3:0] S_DIVY  = 4'd3;
	localparam logic [3:0] S_CX    = 4'd4;
	localparam logic [3:0] S_CY    = 4'd5;
	localparam logic [3:0] S_LDY   = 4'd6;
	localparam logic [3:0] S_MXX   = 4'd7;
	localparam logic [3:0] S_MYY   = 4'd8;
	localparam logic [3:0] S_MXY   = 4'd9;
	localparam logic [3:0] S_UPD   = 4'd10;
	localparam logic [3:0] S_BX    = 4'd11;
	localparam logic [3:0] S_BY    = 4'd12;
	localparam logic [3:0] S_OUT   = 4'd13;
	localparam logic [3:0] S_START = 4'd14;

	// ---------------- configuration
	logic [mpe_pkg::OFS_W-1:0]  ofs_q;
	logic [SW-1:0]              wid_q, hgt_q;
	logic [mpe_pkg::ITER_W-1:0] iters_q;
	logic [mpe_pkg::SCL_W-1:0]  scale_q;
	logic signed [FW-1:0]       cre_q, cim_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofs_q   <= '0;
			wid_q   <= mpe_pkg::WIDTH_RST;
			hgt_q   <= mpe_pkg::HEIGHT_RST;
			iters_q <= mpe_pkg::ITERS_RST;
			scale_q <= mpe_pkg::SCALE_RST;
			cre_q   <= mpe_pkg::CRE_RST;
			cim_q   <= mpe_pkg::CIM_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mpe_pkg::REG_OFFSET: ofs_q   <= cfg_data[mpe_pkg::OFS_W-1:0];
				mpe_pkg::REG_WIDTH:  wid_q   <= cfg_data[SW-1:0];
				mpe_pkg::REG_HEIGHT: hgt_q   <= cfg_data[SW-1:0];
				mpe_pkg::REG_ITERS:  iters_q <= cfg_data[mpe_pkg::ITER_W-1:0];
				mpe_pkg::REG_SCALE:  scale_q <= cfg_data[mpe_pkg::SCL_W-1:0];
				mpe_pkg::REG_CRE:    cre_q   <= cfg_data;
				mpe_pkg::REG_CIM:    cim_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamped sides
	logic [SW-1:0] w_c, h_c;
	always_comb begin
		w_c = (32'(wid_q) > 32'(MAX_SIDE)) ? SW'(MAX_SIDE) : wid_q;
		h_c = (32'(hgt_q) > 32'(MAX_SIDE)) ? SW'(MAX_SIDE) : hgt_q;
	end

	// ---------------- shared divider
	logic              div_start, div_done;
	logic [NUM_W-1:0]  div_num, div_quo;
	logic [SW-1:0]     div_den, div_rem;

	mpe_div #(.NUM_W(NUM_W), .DEN_W(SW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .done(div_done), .quo(div_quo), .rem(div_rem)
	);

	// ---------------- shared multiplier (signed 33x33 inputs, one per cycle)
	logic signed [FW:0]   ma, mb;
	logic signed [PW+1:0] prod;
	logic signed [PW+1:0] prod_q;
	logic signed [PW+1:0] pfl;   // floored product
	assign prod = ma * mb;
	assign pfl  = prod_q >>> FRAC_BITS;

	// ---------------- datapath registers
	logic [3:0]            st_q;
	logic [IW-1:0]         idx_q;
	logic [TW-1:0]         total_q;
	logic [SW-1:0]         row_q;
	logic signed [FW:0]    nx_q, ny_q;
	logic signed [FW-1:0]  cx_q, cy_q, zx_q, zy_q;
	logic signed [PW+1:0]  xx_q, yy_q;
	logic [mpe_pkg::ITER_W-1:0] k_q;
	logic                  esc_q;

	// saturation to 32-bit
	function automatic logic signed [31:0] sat(input logic signed [PW+1:0] v);
		logic signed [PW+1:0] hi, lo;
		hi = (PW+2)'(32'sh7fffffff);
		lo = (PW+2)'(32'sh80000000);
		if (v > hi) sat = 32'sh7fffffff;
		else if (v < lo) sat = 32'sh80000000;
		else sat = v[31:0];
	endfunction

	// escape test on floored squares of the current z
	logic signed [PW+1:0] four;
	logic                 esc_c, round_done;
	assign four       = (PW+2)'(4) <<< FRAC_BITS;
	assign esc_c      = (xx_q + yy_q) > four;
	assign round_done = esc_c || (k_q == iters_q);

	// byte conversion: floor(|a|*200 >> F) saturated, via multiplier in S_BX/S_BY
	logic [PW+1:0] bmag;
	always_comb begin
		bmag = (prod_q < 0) ? -prod_q : prod_q;
		bmag = bmag >> FRAC_BITS;
	end
	logic [mpe_pkg::BYTE_W-1:0] bsat;
	assign bsat = (bmag > (PW+2)'(255)) ? 8'd255 : bmag[7:0];

	// multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		case (st_q)
			S_CX:  begin ma = nx_q; mb = {2'b00, scale_q}; end
			S_CY:  begin ma = ny_q; mb = {2'b00, scale_q}; end
			S_MXX: begin ma = (FW+1)'(zx_q); mb = (FW+1)'(zx_q); end
			S_MYY: begin ma = (FW+1)'(zy_q); mb = (FW+1)'(zy_q); end
			S_MXY: begin ma = (FW+1)'(zx_q); mb = (FW+1)'(zy_q); end
			S_BX:  begin ma = (FW+1)'(zx_q); mb = 33'sd200; end
			S_BY:  begin ma = (FW+1)'(zy_q); mb = 33'sd200; end
			default: ;
		endcase
	end

	// divider operand select
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = w_c;
		case (st_q)
			S_START: begin
				div_start = 1'b1;
				div_num   = NUM_W'(idx_q);
			end
			S_DIVI: if (div_done) begin
				div_start = 1'b1;
				div_num   = NUM_W'({div_rem, FRAC_BITS'(0)});
			end
			S_DIVX: if (div_done) begin
				div_start = 1'b1;
				div_num   = NUM_W'({row_q, FRAC_BITS'(0)});
				div_den   = h_c;
			end
			default: ;
		endcase
	end

	logic signed [FW:0] half;
	assign half = (FW+1)'(1) <<< (FRAC_BITS - 1);

	logic [IW-1:0] idx_sum;
	assign idx_sum = IW'(pixel_index) + IW'(ofs_q);

	logic [TW-1:0] total_c;
	assign total_c = TW'(w_c) * TW'(h_c);

	// quarter decode
	logic [TW-1:0] t4, t2, t34;
	logic [mpe_pkg::QTR_W-1:0] q_c;
	logic [TW:0] t34w;
	logic [CW-1:0] base_c;
	always_comb begin
		t34w = ({1'b0, total_q} + {total_q, 1'b0}) >> 2;
		t4   = total_q >> 2;
		t2   = total_q >> 1;
		t34  = t34w[TW-1:0];
		if (CW'(idx_q) < CW'(t4))       begin q_c = 2'd0; base_c = '0; end
		else if (CW'(idx_q) < CW'(t2))  begin q_c = 2'd1; base_c = CW'(t4); end
		else if (CW'(idx_q) < CW'(t34)) begin q_c = 2'd2; base_c = CW'(t2); end
		else                            begin q_c = 2'd3; base_c = CW'(t34); end
	end
	logic [CW-1:0] qaddr_c;
	assign qaddr_c = CW'(idx_q) - base_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			strobe <= 1'b0;
		end else begin
			strobe <= 1'b0;
			unique case (st_q)
				S_IDLE: if (start) begin
					if (CW'(idx_sum) >= CW'(total_c)) st_q <= S_IDLE;
					else st_q <= S_START;
				end
				S_START: st_q <= S_DIVI;
				S_DIVI:  if (div_done) st_q <= S_DIVX;
				S_DIVX:  if (div_done) st_q <= S_DIVY;
				S_DIVY:  if (div_done) st_q <= S_CX;
				S_CX:    st_q <= S_CY;
				S_CY:    st_q <= S_LDY;
				S_LDY:   st_q <= S_MXX;
				S_MXX:   st_q <= S_MYY;
				S_MYY:   st_q <= S_MXY;
				S_MXY:   st_q <= S_UPD;
				// escape or round count reached: convert the current z
				S_UPD:   st_q <= round_done ? S_BX : S_MXX;
				S_BX:    st_q <= S_BY;
				S_BY:    st_q <= S_OUT;
				S_OUT: begin
					st_q   <= S_IDLE;
					strobe <= 1'b1;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod;
		case (st_q)
			S_IDLE: begin
				idx_q   <= idx_sum;
				total_q <= total_c;
			end
			S_DIVI: if (div_done) row_q <= div_quo[SW-1:0];
			S_DIVX: if (div_done) nx_q <= (FW+1)'(div_quo) - half;
			S_DIVY: if (div_done) ny_q <= (FW+1)'(div_quo) - half;
			S_CY: begin
				cx_q <= sat(pfl + (PW+2)'(cre_q));
				zx_q <= sat(pfl + (PW+2)'(cre_q));
				k_q  <= '0;
			end
			S_LDY: begin
				cy_q <= sat(pfl + (PW+2)'(cim_q));
				zy_q <= sat(pfl + (PW+2)'(cim_q));
			end
			S_MYY: xx_q <= pfl;
			S_MXY: yy_q <= pfl;
			S_UPD: begin
				esc_q <= esc_c;
				if (!round_done) begin
					zx_q <= sat(xx_q - yy_q + (PW+2)'(cx_q));
					zy_q <= sat((pfl <<< 1) + (PW+2)'(cy_q));
					k_q  <= k_q + 1'b1;
				end
			end
			S_BY: real_byte <= esc_q ? 8'd255 : bsat;
			S_OUT: begin
				imag_byte       <= esc_q ? 8'd255 : bsat;
				quarter         <= q_c;
				quarter_address <= qaddr_c[mpe_pkg::ADDR_W-1:0];
			end
			default: ;
		endcase
	end

	assign busy = (st_q != S_IDLE);

	initial_check: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy) else $error("strobe while busy");

	strobe_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe) else $error("strobe longer than one cycle");

	state_legal: assert property (@(posedge clk) disable iff (!arst_n)
		st_q <= S_START) else $error("illegal sequencer state");

endmodule

// File: rtl/mpe_div.sv
// ----------------------------------------------------------------------------
// mpe_div
// Restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module mpe_div #(
	parameter int NUM_W = 40,
	parameter int DEN_W = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W-1:0] rem
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] q_q;
	logic [DEN_W:0]   r_q;
	logic [DEN_W-1:0] d_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W+1:0] diff;

	always_comb begin
		trial = {r_q[DEN_W-1:0], q_q[NUM_W-1]};
		diff  = {1'b0, trial} - {2'b00, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (!diff[DEN_W+1]) begin
				r_q <= diff[DEN_W:0];
				q_q <= {q_q[NUM_W-2:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign quo = q_q;
	assign rem = r_q[DEN_W-1:0];

endmodule

// File: bench/mandelbrot_pixel_engine_tb.sv
// ----------------------------------------------------------------------------
// mandelbrot_pixel_engine_tb
// Self-checking bench: a fixed-point escape-time predictor runs beside the DUT.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  CYCLE_LIMIT = 30000000;
	localparam int  SETTLE      = 40;
	// index past the register list: the write must be dropped
	localparam logic [mpe_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct {
		logic [mpe_pkg::QTR_W-1:0]  qtr;
		logic [mpe_pkg::ADDR_W-1:0] addr;
		logic [mpe_pkg::BYTE_W-1:0] re_b;
		logic [mpe_pkg::BYTE_W-1:0] im_b;
	} pixel_t;

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	logic [mpe_pkg::IDX_W-1:0]      pixel_index;
	logic                           strobe;
	logic [mpe_pkg::QTR_W-1:0]      quarter;
	logic [mpe_pkg::ADDR_W-1:0]     quarter_address;
	logic [mpe_pkg::BYTE_W-1:0]     real_byte;
	logic [mpe_pkg::BYTE_W-1:0]     imag_byte;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [mpe_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [mpe_pkg::CFG_DATA_W-1:0] cfg_data;

	mandelbrot_pixel_engine dut (.*);

	// Shadow copy of the view registers
	logic [mpe_pkg::OFS_W-1:0]         sh_offset;
	logic [mpe_pkg::SIDE_W-1:0]        sh_width;
	logic [mpe_pkg::SIDE_W-1:0]        sh_height;
	logic [mpe_pkg::ITER_W-1:0]        sh_iters;
	logic [mpe_pkg::SCL_W-1:0]         sh_scale;
	logic signed [mpe_pkg::FIX_W-1:0]  sh_cre;
	logic signed [mpe_pkg::FIX_W-1:0]  sh_cim;

	pixel_t pending_pixels[$];
	int     errors;
	int     cycles;
	int     gap_pct;
	// outputs sampled mid-cycle, away from the clock edge
	logic   busy_s, ready_s;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(negedge clk) begin
		busy_s  <= busy;
		ready_s <= cfg_ready;
	end

	// ---------------- fixed-point predictor ----------------
	function automatic longint sat_fix(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// exact product, floored (arithmetic shift rounds toward minus infinity)
	function automatic longint fix_mul(input longint a, input longint b);
		longint p;
		p = a * b;
		return p >>> mpe_pkg::FRAC_BITS_DEF;
	endfunction

	function automatic longint fix_sq(input longint a);
		longint m;
		m = (a < 0) ? -a : a;
		return (m * m) >> mpe_pkg::FRAC_BITS_DEF;
	endfunction

	function automatic bit outside_radius(input longint x, input longint y);
		return (fix_sq(x) + fix_sq(y)) > (64'sd4 <<< mpe_pkg::FRAC_BITS_DEF);
	endfunction

	function automatic logic [mpe_pkg::BYTE_W-1:0] fix_to_byte(input longint a);
		longint m, v;
		m = (a < 0) ? -a : a;
		v = (m * 200) >> mpe_pkg::FRAC_BITS_DEF;
		return (v > 255) ? 8'd255 : v[7:0];
	endfunction

	function automatic longint side_of(input logic [mpe_pkg::SIDE_W-1:0] s);
		return (s > mpe_pkg::MAX_SIDE_DEF) ? mpe_pkg::MAX_SIDE_DEF : longint'(s);
	endfunction

	// Returns 1 when the pixel lands inside the image; r gets the expected word.
	function automatic bit escape_pixel(input logic [mpe_pkg::IDX_W-1:0] pix,
		output pixel_t r);
		longint w, h, total, idx, col, row, nx, ny, cx, cy, zx, zy, nxr, nyi, base;
		longint half;
		int     k;
		bit     esc;
		w     = side_of(sh_width);
		h     = side_of(sh_height);
		total = w * h;
		idx   = longint'(pix) + longint'(sh_offset);
		half  = 64'sd1 <<< (mpe_pkg::FRAC_BITS_DEF - 1);
		r = '{default: '0};
		if (idx >= total) return 1'b0;
		col = idx % w;
		row = idx / w;
		nx  = ((col << mpe_pkg::FRAC_BITS_DEF) / w) - half;
		ny  = ((row << mpe_pkg::FRAC_BITS_DEF) / h) - half;
		cx  = sat_fix(fix_mul(nx, longint'(sh_scale)) + longint'(sh_cre));
		cy  = sat_fix(fix_mul(ny, longint'(sh_scale)) + longint'(sh_cim));
		zx  = cx;
		zy  = cy;
		esc = outside_radius(zx, zy);
		for (k = 0; k < int'(sh_iters) && !esc; k++) begin
			nxr = fix_mul(zx, zx) - fix_mul(zy, zy);
			nyi = 2 * fix_mul(zx, zy);
			zx  = sat_fix(nxr + cx);
			zy  = sat_fix(nyi + cy);
			esc = outside_radius(zx, zy);
		end
		if (idx < total / 4) begin
			r.qtr = 2'd0; base = 0;
		end else if (idx < total / 2) begin
			r.qtr = 2'd1; base = total / 4;
		end else if (idx < total * 3 / 4) begin
			r.qtr = 2'd2; base = total / 2;
		end else begin
			r.qtr = 2'd3; base = total * 3 / 4;
		end
		r.addr = mpe_pkg::ADDR_W'(idx - base);
		r.re_b = esc ? 8'd255 : fix_to_byte(zx);
		r.im_b = esc ? 8'd255 : fix_to_byte(zy);
		return 1'b1;
	endfunction

	// ---------------- result checker ----------------
	always @(negedge clk) begin
		pixel_t e;
		if (arst_n && strobe) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected result word: quarter %0d addr %0d",
					quarter, quarter_address);
				errors++;
			end else begin
				e = pending_pixels.pop_front();
				if (quarter !== e.qtr) begin
					$error("quarter: expected %0d actual %0d", e.qtr, quarter);
					errors++;
				end
				if (quarter_address !== e.addr) begin
					$error("quarter_address: expected %0d actual %0d",
						e.addr, quarter_address);
					errors++;
				end
				if (real_byte !== e.re_b) begin
					$error("real_byte: expected %0d actual %0d", e.re_b, real_byte);
					errors++;
				end
				if (imag_byte !== e.im_b) begin
					$error("imag_byte: expected %0d actual %0d", e.im_b, imag_byte);
					errors++;
				end
			end
		end
	end

	// ---------------- drivers ----------------
	// start stays high after a take; busy keeps an in-image word from being taken
	// twice, and the next word or idle_gap overwrites it.
	task automatic send_pixel(input logic [mpe_pkg::IDX_W-1:0] pix);
		pixel_t r;
		bit     taken;
		start       <= 1'b1;
		pixel_index <= pix;
		do begin
			@(negedge clk);
			@(posedge clk);
			taken = !busy_s;
		end while (!taken);
		if (escape_pixel(pix, r)) pending_pixels.push_back(r);
	endtask

	task automatic idle_gap();
		if ($urandom_range(99) < gap_pct) begin
			start       <= 1'b0;
			pixel_index <= mpe_pkg::IDX_W'($urandom);
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// drop start, let every word come out, then give the sequencer time
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		do begin
			@(negedge clk);
			@(posedge clk);
		end while (pending_pixels.size() != 0 || busy_s);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [mpe_pkg::CFG_IDX_W-1:0] ix,
		input logic [mpe_pkg::CFG_DATA_W-1:0] d);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= ix;
		cfg_data  <= d;
		do begin
			@(negedge clk);
			@(posedge clk);
			taken = ready_s;
		end while (!taken);
		case (ix)
			mpe_pkg::REG_OFFSET: sh_offset = d[mpe_pkg::OFS_W-1:0];
			mpe_pkg::REG_WIDTH:  sh_width  = d[mpe_pkg::SIDE_W-1:0];
			mpe_pkg::REG_HEIGHT: sh_height = d[mpe_pkg::SIDE_W-1:0];
			mpe_pkg::REG_ITERS:  sh_iters  = d[mpe_pkg::ITER_W-1:0];
			mpe_pkg::REG_SCALE:  sh_scale  = d[mpe_pkg::SCL_W-1:0];
			mpe_pkg::REG_CRE:    sh_cre    = d;
			mpe_pkg::REG_CIM:    sh_cim    = d;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_view(input logic [mpe_pkg::OFS_W-1:0] ofs, input int w,
		input int h, input int it, input logic [mpe_pkg::SCL_W-1:0] scl,
		input logic [mpe_pkg::FIX_W-1:0] re, input logic [mpe_pkg::FIX_W-1:0] im);
		write_reg(mpe_pkg::REG_OFFSET, mpe_pkg::CFG_DATA_W'(ofs));
		write_reg(mpe_pkg::REG_WIDTH, w);
		write_reg(mpe_pkg::REG_HEIGHT, h);
		write_reg(mpe_pkg::REG_ITERS, it);
		write_reg(mpe_pkg::REG_SCALE, mpe_pkg::CFG_DATA_W'(scl));
		write_reg(mpe_pkg::REG_CRE, re);
		write_reg(mpe_pkg::REG_CIM, im);
	endtask

	// ---------------- tests ----------------
	// Reset view: first and last pixel, quarter boundaries, out-of-image sum.
	task automatic test_reset_view();
		send_pixel(24'd0);
		send_pixel(24'hFFFFFF);
		send_pixel(24'd4194304);
		send_pixel(24'd8388607);
		send_pixel(24'd12582912);
		drain();
		write_reg(mpe_pkg::REG_OFFSET, 32'd1);
		send_pixel(24'hFFFFFF);      // sum equals width*height: no word
		drain();
	endtask

	// Tiny image, full scale, extreme centres, zero rounds.
	task automatic test_small_image();
		set_view(24'd2, 3, 5, 0, 31'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
		send_pixel(24'd0);
		send_pixel(24'd12);
		send_pixel(24'd13);          // lands past the image
		drain();
		// zero scale: every point is the centre
		set_view(24'd0, 7, 3, 1023, 31'd0, 32'hF0000000, 32'h04000000);
		send_pixel(24'd20);
		send_pixel(24'd5);
		drain();
	endtask

	// Side clamp, zero side, max offset, dropped register write.
	task automatic test_corners();
		set_view(24'hFFFFFF, 8191, 1, 3, 31'd268435, 32'd0, 32'd0);
		send_pixel(24'hFFFFFF);
		send_pixel(24'd0);
		drain();
		set_view(24'd0, 8191, 2, 5, 31'h10000000, 32'hE0000000, 32'd0);
		send_pixel(24'd8191);
		send_pixel(24'd0);
		drain();
		write_reg(mpe_pkg::REG_WIDTH, 32'd0);
		send_pixel(24'd0);
		send_pixel(24'd1);
		drain();
		write_reg(mpe_pkg::REG_WIDTH, 32'd16);
		write_reg(REG_UNUSED, 32'hFFFFFFFF);
		send_pixel(24'd31);
		send_pixel(24'd17);
		drain();
	endtask

	task automatic random_view();
		int w, h, it;
		logic [mpe_pkg::FIX_W-1:0] re, im;
		logic [mpe_pkg::SCL_W-1:0] scl;
		w  = ($urandom_range(2) == 0) ? $urandom_range(8191) : $urandom_range(1, 40);
		h  = ($urandom_range(2) == 0) ? $urandom_range(8191) : $urandom_range(1, 40);
		if (w == 0 && $urandom_range(3) != 0) w = 1;
		if (h == 0 && $urandom_range(3) != 0) h = 1;
		it = ($urandom_range(15) == 0) ? $urandom_range(512, 1023) : $urandom_range(16);
		if ($urandom_range(1)) begin
			// near the set: centre within +-2, modest scale
			re  = mpe_pkg::FIX_W'($signed($urandom_range(0, 32'h3FFFFFFF)) - 32'sh20000000);
			im  = mpe_pkg::FIX_W'($signed($urandom_range(0, 32'h3FFFFFFF)) - 32'sh20000000);
			scl = mpe_pkg::SCL_W'($urandom_range(0, 32'h20000000));
		end else begin
			re  = $urandom;
			im  = $urandom;
			scl = mpe_pkg::SCL_W'($urandom);
		end
		set_view($urandom_range(1) ? mpe_pkg::OFS_W'(0) : mpe_pkg::OFS_W'($urandom),
			w, h, it, scl, re, im);
	endtask

	task automatic test_random_phase(input int pct, input int n_items);
		int  n, j;
		longint total, ofs;
		logic [mpe_pkg::IDX_W-1:0] pix;
		gap_pct = pct;
		n = 0;
		while (n < n_items) begin
			random_view();
			total = side_of(sh_width) * side_of(sh_height);
			ofs   = longint'(sh_offset);
			for (j = 0; j < 40; j++) begin
				if (total > ofs && $urandom_range(9) != 0)
					pix = mpe_pkg::IDX_W'($urandom_range(0, 32'(total - 1 - ofs)));
				else
					pix = mpe_pkg::IDX_W'($urandom);
				send_pixel(pix);
				idle_gap();
				n++;
			end
			drain();
		end
	endtask

	initial begin
		errors      = 0;
		cycles      = 0;
		gap_pct     = 0;
		arst_n      = 1'b0;
		start       = 1'b0;
		pixel_index = '0;
		cfg_valid   = 1'b0;
		cfg_index   = mpe_pkg::REG_OFFSET;
		cfg_data    = '0;
		sh_offset   = '0;
		sh_width    = mpe_pkg::WIDTH_RST;
		sh_height   = mpe_pkg::HEIGHT_RST;
		sh_iters    = mpe_pkg::ITERS_RST;
		sh_scale    = mpe_pkg::SCALE_RST;
		sh_cre      = mpe_pkg::CRE_RST;
		sh_cim      = mpe_pkg::CIM_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_view();
		test_small_image();
		test_corners();
		test_random_phase(20, 400);
		test_random_phase(69, 400);
		test_random_phase(0, 400);

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: filelist.f
rtl/mpe_pkg.sv
rtl/mpe_div.sv
rtl/mandelbrot_pixel_engine.sv
bench/mandelbrot_pixel_engine_tb.sv
